// File: rtl/ugb_pkg.sv
// ----------------------------------------------------------------------------
// ugb_pkg
// Shared types and code point constants of the grapheme boundary finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ugb_pkg;

   localparam int CP_BITS    = 21;
   localparam int RSP_BITS   = 16;
   localparam int RSP_SLOTS  = 3;
   localparam int EXT_RANGES = 14;

   localparam logic [CP_BITS-1:0] CP_ZWJ   = 21'h0200d;
   localparam logic [CP_BITS-1:0] CP_CR    = 21'h0000d;
   localparam logic [CP_BITS-1:0] CP_LF    = 21'h0000a;
   localparam logic [CP_BITS-1:0] CP_RI_LO = 21'h1f1e6;
   localparam logic [CP_BITS-1:0] CP_RI_HI = 21'h1f1ff;
   localparam logic [CP_BITS-1:0] CP_BAD   = 21'h0fffd;

   localparam logic [7:0] CONT_MASK = 8'hc0;
   localparam logic [7:0] CONT_TAG  = 8'h80;
   localparam logic [7:0] LOW6_MASK = 8'h3f;

   // Extending mark ranges, low and high bound of each, inclusive.
   localparam logic [CP_BITS-1:0] EXT_LO [EXT_RANGES] = '{
      21'h00300, 21'h00483, 21'h00591, 21'h00610, 21'h0064b, 21'h00900, 21'h01ab0,
      21'h01dc0, 21'h020d0, 21'h0fe00, 21'h0fe20, 21'h1f3fb, 21'he0100, 21'he0020
   };
   localparam logic [CP_BITS-1:0] EXT_HI [EXT_RANGES] = '{
      21'h0036f, 21'h00489, 21'h005bd, 21'h0061a, 21'h0065f, 21'h00903, 21'h01aff,
      21'h01dff, 21'h020ff, 21'h0fe0f, 21'h0fe2f, 21'h1f3ff, 21'he01ef, 21'he007f
   };

   typedef struct packed {
      logic                valid;
      logic [RSP_BITS-1:0] offset;
      logic                last;
   } rsp_slot_type;

   typedef rsp_slot_type [RSP_SLOTS-1:0] rsp_bundle_type;

   typedef struct packed {
      logic emit;
      logic ri_odd;
   } join_result_type;

endpackage

// File: rtl/ugb_join.sv
// ----------------------------------------------------------------------------
// ugb_join
// Decides whether a finished code point starts a new grapheme cluster.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ugb_join
   import ugb_pkg::*;
(
   input  logic [CP_BITS-1:0] cur,
   input  logic [CP_BITS-1:0] prev,
   input  logic               have_prev,
   input  logic               ri_odd,
   output join_result_type    result
);

   logic is_ext;
   logic cur_ri;
   logic prev_ri;
   logic joins;

   always_comb begin
      is_ext = 1'b0;
      for (int i = 0; i < EXT_RANGES; i++) begin
         if (cur >= EXT_LO[i] && cur <= EXT_HI[i]) begin
            is_ext = 1'b1;
         end
      end
   end

   assign cur_ri  = (cur >= CP_RI_LO) && (cur <= CP_RI_HI);
   assign prev_ri = (prev >= CP_RI_LO) && (prev <= CP_RI_HI);

   // A pair of regional indicators is settled by the run parity alone.
   always_comb begin
      if (prev_ri && cur_ri) begin
         joins = ri_odd;
      end else begin
         joins = is_ext || (cur == CP_ZWJ) || (prev == CP_ZWJ) ||
                 ((prev == CP_CR) && (cur == CP_LF));
      end
   end

   assign result.emit   = !have_prev || !joins;
   assign result.ri_odd = cur_ri ? !ri_odd : 1'b0;

endmodule

// File: rtl/ugb_decoder.sv
// ----------------------------------------------------------------------------
// ugb_decoder
// UTF-8 decode state and boundary evaluation for one byte per load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ugb_decoder
   import ugb_pkg::*;
#(
   parameter int OFFSET_BITS = 16
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  logic [7:0]     data_byte,
   input  logic           end_of_text,
   output rsp_bundle_type bundle
);

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic [CP_BITS-1:0]     value_ff, value_in;
   logic [1:0]             remain_ff, remain_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic                   pending_ff, pending_in;
   logic [CP_BITS-1:0]     prev_ff, prev_in;
   logic                   have_prev_ff, have_prev_in;
   logic                   ri_odd_ff, ri_odd_in;

   logic                   is_cont;
   logic                   cut_short;
   logic [CP_BITS-1:0]     prev_mid;
   logic                   have_prev_mid;
   logic                   ri_odd_mid;
   logic [CP_BITS-1:0]     new_value;
   logic [1:0]             new_remain;
   logic [OFFSET_BITS-1:0] new_start;
   logic                   finish_now;
   join_result_type        join_cut;
   join_result_type        join_new;
   rsp_slot_type           res_cut, res_new, res_end;

   function automatic logic [RSP_BITS-1:0] to_rsp(input logic [OFFSET_BITS-1:0] x);
      logic [31:0] w;
      w = 32'(x);
      return w[RSP_BITS-1:0];
   endfunction

   assign is_cont   = pending_ff && (remain_ff != 2'd0) &&
                      ((data_byte & CONT_MASK) == CONT_TAG);
   assign cut_short = !is_cont && pending_ff;

   ugb_join u_join_cut (
      .cur       (value_ff),
      .prev      (prev_ff),
      .have_prev (have_prev_ff),
      .ri_odd    (ri_odd_ff),
      .result    (join_cut)
   );

   assign prev_mid      = cut_short ? value_ff : prev_ff;
   assign have_prev_mid = cut_short ? 1'b1 : have_prev_ff;
   assign ri_odd_mid    = cut_short ? join_cut.ri_odd : ri_odd_ff;

   always_comb begin
      new_start  = count_ff;
      new_remain = 2'd0;
      new_value  = CP_BAD;
      if (is_cont) begin
         new_value  = {value_ff[CP_BITS-7:0], data_byte[5:0] & LOW6_MASK[5:0]};
         new_remain = remain_ff - 2'd1;
         new_start  = start_ff;
      end else if (data_byte[7] == 1'b0) begin
         new_value = CP_BITS'(data_byte);
      end else if (data_byte[7:5] == 3'b110) begin
         new_value  = CP_BITS'(data_byte[4:0]);
         new_remain = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
         new_value  = CP_BITS'(data_byte[3:0]);
         new_remain = 2'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
         new_value  = CP_BITS'(data_byte[2:0]);
         new_remain = 2'd3;
      end
   end

   assign finish_now = (new_remain == 2'd0) || end_of_text;

   ugb_join u_join_new (
      .cur       (new_value),
      .prev      (prev_mid),
      .have_prev (have_prev_mid),
      .ri_odd    (ri_odd_mid),
      .result    (join_new)
   );

   assign count_in = (count_ff == OFFSET_MAX) ? count_ff : count_ff + OFFSET_BITS'(1);

   assign res_cut = '{valid: cut_short && join_cut.emit, offset: to_rsp(start_ff),
                      last: 1'b0};
   assign res_new = '{valid: finish_now && join_new.emit, offset: to_rsp(new_start),
                      last: 1'b0};
   assign res_end = '{valid: end_of_text, offset: to_rsp(count_in), last: 1'b1};

   // Pack the results so that slot 0 holds the first one due.
   always_comb begin
      bundle = '0;
      if (res_cut.valid) begin
         bundle[0] = res_cut;
         if (res_new.valid) begin
            bundle[1] = res_new;
            bundle[2] = res_end;
         end else begin
            bundle[1] = res_end;
         end
      end else if (res_new.valid) begin
         bundle[0] = res_new;
         bundle[1] = res_end;
      end else begin
         bundle[0] = res_end;
      end
   end

   always_comb begin
      value_in     = new_value;
      start_in     = new_start;
      remain_in    = new_remain;
      pending_in   = 1'b1;
      prev_in      = prev_mid;
      have_prev_in = have_prev_mid;
      ri_odd_in    = ri_odd_mid;
      if (finish_now) begin
         remain_in    = 2'd0;
         pending_in   = 1'b0;
         prev_in      = new_value;
         have_prev_in = 1'b1;
         ri_odd_in    = join_new.ri_odd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (load && end_of_text)) begin
         count_ff     <= '0;
         value_ff     <= '0;
         remain_ff    <= 2'd0;
         start_ff     <= '0;
         pending_ff   <= 1'b0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         ri_odd_ff    <= 1'b0;
      end else if (load) begin
         count_ff     <= count_in;
         value_ff     <= value_in;
         remain_ff    <= remain_in;
         start_ff     <= start_in;
         pending_ff   <= pending_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         ri_odd_ff    <= ri_odd_in;
      end
   end

endmodule

// File: rtl/ugb_rsp_queue.sv
// ----------------------------------------------------------------------------
// ugb_rsp_queue
// Three-slot result register that drains one boundary per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ugb_rsp_queue
   import ugb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  rsp_bundle_type      bundle,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   rsp_bundle_type slot_ff;
   logic           take;

   assign take       = slot_ff[0].valid && rsp_tready;
   assign can_load   = !slot_ff[1].valid && (!slot_ff[0].valid || rsp_tready);
   assign rsp_tvalid = slot_ff[0].valid;
   assign rsp_tdata  = slot_ff[0].offset;
   assign rsp_tlast  = slot_ff[0].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RSP_SLOTS; i++) begin
            slot_ff[i].valid <= 1'b0;
         end
      end else if (load) begin
         slot_ff <= bundle;
      end else if (take) begin
         for (int i = 0; i < RSP_SLOTS - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
         slot_ff[RSP_SLOTS-1].valid <= 1'b0;
      end
   end

endmodule

// File: rtl/utf8_grapheme_boundary_finder.sv
// ----------------------------------------------------------------------------
// utf8_grapheme_boundary_finder
// Streams UTF-8 text bytes and reports the byte offset of each grapheme
// cluster start, followed by the text length.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                            Marker
//   req_*     in         tdata[7:0] = data_byte             tlast = end_of_text
//   rsp_*     out        tdata[15:0] = boundary_offset      tlast = last_boundary
//
// A request waits in the input register and is decoded into the three-slot
// result register, where its first boundary is offered. One request per
// cycle is taken while each yields at most one boundary and rsp_tready is
// high; two or three boundaries hold the next request back.
// A result stall fills the slots and the input register, then req_tready
// drops. Reset and the final byte of a text both clear the decode state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_grapheme_boundary_finder
   import ugb_pkg::*;
#(
   parameter int OFFSET_BITS = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tlast,   // end_of_text
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,   // [15:0] boundary_offset
   output logic                rsp_tlast    // last_boundary
);

   // Input register: one request waiting to be evaluated.
   logic           in_valid_ff;
   logic [7:0]     in_data_ff;
   logic           in_last_ff;
   logic           load;
   logic           can_load;
   rsp_bundle_type bundle;

   // The held request is evaluated and moved on when the result slots will
   // be empty at the end of this cycle. No request is taken during reset.
   assign load       = in_valid_ff && can_load;
   assign req_tready = !reset && (!in_valid_ff || load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Decoder: code point assembly, join rules and offset counting. It emits
   // the cut-short boundary, the new code point's boundary and the end
   // boundary, packed in that order.
   ugb_decoder #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_decoder (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .data_byte   (in_data_ff),
      .end_of_text (in_last_ff),
      .bundle      (bundle)
   );

   ugb_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .bundle     (bundle),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
